// ===== hdl/sse_pkg.sv =====
// shared types and constants for the sparse set engine
// no dependencies; compiled first

package sse_pkg;

    localparam int CMD_W        = 3;
    localparam int VAL_W        = 6;
    localparam int COUNT_W      = 7;
    localparam int MAX_DEPTH    = 64;
    localparam int SET_SIZE_DEF = 64;

    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ITERATE  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_DEN,
        S_ACT,
        S_MOV,
        S_IT_PRE,
        S_IT_OUT,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        U_LT,
        U_EQ,
        U_INC,
        U_DEC
    } t_unit_op;

endpackage

// ===== hdl/sse_if.sv =====
// valid/ready channel interfaces for command and result transactions
// depends on sse_pkg for field widths

interface sse_in_if import sse_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface sse_out_if import sse_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [VAL_W-1:0]   member;
    logic               member_valid;
    logic [COUNT_W-1:0] set_count;
    logic               last;

    modport source (output valid, output found, output member, output member_valid,
                    output set_count, output last, input ready);
    modport sink   (input valid, input found, input member, input member_valid,
                    input set_count, input last, output ready);
endinterface

// ===== hdl/sse_unit.sv =====
// shared compare / increment / decrement unit used by the sequencer
// depends on sse_pkg

module sse_unit import sse_pkg::*; (
    input  t_unit_op           i_op,
    input  logic [COUNT_W-1:0] i_a,
    input  logic [COUNT_W-1:0] i_b,
    output logic [COUNT_W-1:0] o_y,
    output logic               o_flag
);

    always_comb begin
        o_y    = i_a;
        o_flag = 1'b0;
        case (i_op)
            U_LT:    o_flag = (i_a < i_b);
            U_EQ:    o_flag = (i_a == i_b);
            U_INC:   o_y = i_a + COUNT_W'(1);
            U_DEC:   o_y = i_a - COUNT_W'(1);
            default: o_y = i_a;
        endcase
    end

endmodule

// ===== hdl/sparse_set_engine.sv =====
// top level of the sparse set engine: sequencer, tables and result register
// depends on sse_pkg, sse_if and sse_unit

// Holds a set of values below SET_SIZE (at most 64, the value field's range) as
// a sparse set: a position table indexed by value and a dense member table,
// both single-port memories with registered reads, plus a member count. One
// command is taken at a time; the block is not ready until the command's last
// result has been loaded into the output register. After acceptance, clear and
// unknown commands and iterate on an empty set go straight to the response;
// contains, add and remove read the position table, then the dense table, then
// act, and remove of a present value adds a move step (the extra table read of
// the last member); iterate prepares and then offers the members in turn. This
// order comes from the chain of registered table reads feeding one shared
// compare/increment unit, and a stall of the result channel lengthens it. The
// tables need no clearing pass after reset: position entries carry
// reset-cleared valid bits and dense entries are only used below the count.

module sparse_set_engine import sse_pkg::*; #(
    parameter int SET_SIZE = SET_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sse_in_if.sink    i_in,
    sse_out_if.source o_out
);

    localparam int DEPTH = (SET_SIZE < MAX_DEPTH) ? SET_SIZE : MAX_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    logic [CMD_W-1:0]   r_cmd;
    logic [VAL_W-1:0]   r_val;
    logic               r_vok;
    logic               r_lt, n_lt;
    logic               r_was, n_was;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_last_pos, n_last_pos;

    // tables
    logic [AW-1:0]      r_pos_mem [DEPTH];
    logic [DEPTH-1:0]   r_pos_vld;
    logic [AW-1:0]      r_pos_rd;
    logic               r_pos_rd_vld;
    logic [VAL_W-1:0]   r_den_mem [DEPTH];
    logic [VAL_W-1:0]   r_den_rd;

    logic               pos_re, pos_we, den_re, den_we;
    logic [AW-1:0]      pos_ra, pos_wa, pos_wd, den_ra, den_wa;
    logic [VAL_W-1:0]   den_wd;

    // result register
    logic               r_ov;
    logic               r_found;
    logic [VAL_W-1:0]   r_member;
    logic               r_member_valid;
    logic [COUNT_W-1:0] r_set_count;
    logic               r_last;

    logic               emit, e_found, e_mvalid, e_last;
    logic [VAL_W-1:0]   e_member;

    t_unit_op           u_op;
    logic [COUNT_W-1:0] u_a, u_b, u_y;
    logic               u_flag;

    logic               accept, out_free, vok_in, it_last;
    logic [AW-1:0]      pos_eff;

    sse_unit u_unit (
        .i_op   (u_op),
        .i_a    (u_a),
        .i_b    (u_b),
        .o_y    (u_y),
        .o_flag (u_flag)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_ov || o_out.ready;
    assign vok_in     = (32'(i_in.value) < 32'(SET_SIZE));
    assign pos_eff    = r_pos_rd_vld ? r_pos_rd : '0;
    assign it_last    = (r_idx == r_last_pos);

    assign o_out.valid        = r_ov;
    assign o_out.found        = r_found;
    assign o_out.member       = r_member;
    assign o_out.member_valid = r_member_valid;
    assign o_out.set_count    = r_set_count;
    assign o_out.last         = r_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.command == CMD_ADD || i_in.command == CMD_REMOVE ||
                        i_in.command == CMD_CONTAINS) begin
                        n_state = S_POS;
                    end else if (i_in.command == CMD_ITERATE && r_count != '0) begin
                        n_state = S_IT_PRE;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_POS:    n_state = S_DEN;
            S_DEN:    n_state = S_ACT;
            S_ACT:    n_state = (r_cmd == CMD_REMOVE && r_was) ? S_MOV : S_RESP;
            S_MOV:    n_state = S_RESP;
            S_IT_PRE: n_state = S_IT_OUT;
            S_IT_OUT: begin
                if (out_free && it_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        pos_re     = 1'b0;
        pos_ra     = i_in.value[AW-1:0];
        pos_we     = 1'b0;
        pos_wa     = r_val[AW-1:0];
        pos_wd     = r_count[AW-1:0];
        den_re     = 1'b0;
        den_ra     = pos_eff;
        den_we     = 1'b0;
        den_wa     = r_count[AW-1:0];
        den_wd     = r_val;
        u_op       = U_LT;
        u_a        = r_count;
        u_b        = r_count;
        n_lt       = r_lt;
        n_was      = r_was;
        n_count    = r_count;
        n_idx      = r_idx;
        n_last_pos = r_last_pos;
        emit       = 1'b0;
        e_found    = 1'b0;
        e_member   = '0;
        e_mvalid   = 1'b0;
        e_last     = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    pos_re = 1'b1;
                    n_was  = 1'b0;
                    if (i_in.command == CMD_ITERATE) begin
                        den_re = 1'b1;
                        den_ra = '0;
                    end
                    if (i_in.command == CMD_CLEAR) begin
                        n_count = '0;
                    end
                end
            end
            S_POS: begin
                u_op   = U_LT;
                u_a    = COUNT_W'(pos_eff);
                u_b    = r_count;
                n_lt   = u_flag;
                den_re = 1'b1;
                den_ra = pos_eff;
            end
            S_DEN: begin
                u_op  = U_EQ;
                u_a   = COUNT_W'(r_den_rd);
                u_b   = COUNT_W'(r_val);
                n_was = r_vok && r_lt && u_flag;
            end
            S_ACT: begin
                if (r_cmd == CMD_ADD && !r_was && r_vok) begin
                    // append at the end of the dense table
                    u_op    = U_INC;
                    u_a     = r_count;
                    den_we  = 1'b1;
                    pos_we  = 1'b1;
                    n_count = u_y;
                end else if (r_cmd == CMD_REMOVE && r_was) begin
                    // fetch the last member to refill the freed slot
                    u_op       = U_DEC;
                    u_a        = r_count;
                    den_re     = 1'b1;
                    den_ra     = u_y[AW-1:0];
                    n_last_pos = u_y[AW-1:0];
                end
            end
            S_MOV: begin
                den_we  = 1'b1;
                den_wa  = pos_eff;
                den_wd  = r_den_rd;
                pos_we  = 1'b1;
                pos_wa  = r_den_rd[AW-1:0];
                pos_wd  = pos_eff;
                n_count = COUNT_W'(r_last_pos);
            end
            S_IT_PRE: begin
                u_op       = U_DEC;
                u_a        = r_count;
                n_last_pos = u_y[AW-1:0];
                n_idx      = '0;
            end
            S_IT_OUT: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_member = r_den_rd;
                    e_mvalid = 1'b1;
                    e_last   = it_last;
                    if (!it_last) begin
                        u_op   = U_INC;
                        u_a    = COUNT_W'(r_idx);
                        n_idx  = u_y[AW-1:0];
                        den_re = 1'b1;
                        den_ra = u_y[AW-1:0];
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_found = r_was;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pos_vld <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (pos_we) begin
                r_pos_vld[pos_wa] <= 1'b1;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload and sequencer scratch
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in.command;
            r_val <= i_in.value;
            r_vok <= vok_in;
        end
        r_lt       <= n_lt;
        r_was      <= n_was;
        r_idx      <= n_idx;
        r_last_pos <= n_last_pos;
        if (emit) begin
            r_found        <= e_found;
            r_member       <= e_member;
            r_member_valid <= e_mvalid;
            r_set_count    <= n_count;
            r_last         <= e_last;
        end
    end

    // position table
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[pos_wa] <= pos_wd;
        end
        if (pos_re) begin
            r_pos_rd     <= r_pos_mem[pos_ra];
            r_pos_rd_vld <= r_pos_vld[pos_ra];
        end
    end

    // dense member table
    always_ff @(posedge i_clk) begin
        if (den_we) begin
            r_den_mem[den_wa] <= den_wd;
        end
        if (den_re) begin
            r_den_rd <= r_den_mem[den_ra];
        end
    end

endmodule

// ===== hdl/sse_checker.sv =====
// port-level checks on the sparse set engine, attached by bind
// depends on the sparse_set_engine port list only

module sse_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);

    // a pending result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one command at a time: busy right after a transaction is taken
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken while previous one in progress");

    // while a mid-iterate result is offered the command side stays closed
    a_iter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("ready while iterate still emitting");

    // no result can appear in the cycle right after a command is taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result faster than the table read path");

endmodule

bind sparse_set_engine sse_checker u_sse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last)
);
